[design/pfde_pkg.sv]
`timescale 1ns / 1ps

package pfde_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;

  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int ADDR_W = $clog2(STORE_BYTES);

  // Unclipped span coordinates: column sums reach x + w + 1, row sums y + h
  localparam int RC_W = 10;
  localparam int RR_W = 8;

  typedef enum logic [2:0] {
    OP_PIXEL = 3'd0,
    OP_HLINE = 3'd1,
    OP_VLINE = 3'd2,
    OP_RECT  = 3'd3,
    OP_FILL  = 3'd4,
    OP_CLEAR = 3'd5,
    OP_READ  = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_WAIT,
    ST_READ,
    ST_FETCH,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    WK_IDLE,
    WK_READ,
    WK_WRITE
  } walk_state_t;

  // Clipped, non-empty block of bytes: columns c0..c1, pages p0..p1,
  // first row bit lo in page p0, last row bit hi in page p1
  typedef struct packed {
    logic [COL_W-1:0]  c0;
    logic [COL_W-1:0]  c1;
    logic [PAGE_W-1:0] p0;
    logic [PAGE_W-1:0] p1;
    logic [2:0]        lo;
    logic [2:0]        hi;
    logic              colour;
    logic              full;
  } span_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [COL_W-1:0]  col,
                                                  input logic [PAGE_W-1:0] page);
    return ADDR_W'(col) + ADDR_W'(ADDR_W'(page) * ADDR_W'(SCREEN_WIDTH));
  endfunction

endpackage

[design/page_framebuffer_draw_engine_core.sv]
`timescale 1ns / 1ps

// Monochrome page-ordered framebuffer with a drawing engine. One command is
// taken at a time; cmd_stall stays high until its work is done. Every byte a
// drawing command touches is read, then written back with a mask, on the
// store; a rectangle outline is drawn as its four sides. After reset the engine
// sweeps the store to zero before it takes the first command. Each command
// returns one beat on the response channel: the addressed byte for an on-screen
// read, zero otherwise. Pixels off the screen are clipped.
module page_framebuffer_draw_engine_core
  import pfde_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [2:0] op,
  input  logic [6:0] x,
  input  logic [5:0] y,
  input  logic [7:0] w,
  input  logic [6:0] h,
  input  logic       colour,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic [7:0] read_data
);

  ctl_state_t        state, state_next;
  op_t               op_q;
  logic [6:0]        x_q;
  logic [5:0]        y_q;
  logic [7:0]        w_q;
  logic [6:0]        h_q;
  logic              colour_q;
  logic [1:0]        k;
  logic              init_pass;
  logic [7:0]        res_data;

  logic              accept;
  logic              walk_start, walk_done;
  logic              last_k;
  logic              rsp_load;
  span_t             span;
  logic              span_empty;
  mem_req_t          req;
  logic [ADDR_W-1:0] raddr, rd_addr;
  logic [7:0]        rdata;
  logic              rd_off;

  logic [RC_W-1:0]   x_e, w_e, rs_c0, rs_len, cend;
  logic [RR_W-1:0]   y_e, yh, rs_r0, rs_r1, r1c;
  logic              rs_full;

  assign accept = cmd_valid && !cmd_stall;
  assign last_k = (op_q == OP_RECT) ? (k == 2'd3) : 1'b1;

  // Build the unclipped span for the current command and edge
  always_comb begin
    x_e     = RC_W'(x_q);
    w_e     = RC_W'(w_q);
    y_e     = RR_W'(y_q);
    yh      = RR_W'(y_q) + RR_W'(h_q);
    rs_c0   = x_e;
    rs_len  = w_e;
    rs_r0   = y_e;
    rs_r1   = y_e;
    rs_full = 1'b0;
    unique case (op_q)
      OP_PIXEL: rs_len = RC_W'(1);
      OP_HLINE: ;
      OP_VLINE: begin
        rs_len = RC_W'(1);
        rs_r1  = yh;
      end
      OP_RECT: begin
        case (k)
          2'd1: begin
            rs_r0 = yh;
            rs_r1 = yh;
          end
          2'd2: begin
            rs_len = RC_W'(1);
            rs_r1  = yh;
          end
          2'd3: begin
            rs_c0  = x_e + w_e;
            rs_len = RC_W'(1);
            rs_r1  = yh;
          end
          default: ;
        endcase
      end
      OP_FILL: rs_r1 = yh;
      OP_CLEAR: begin
        rs_c0   = '0;
        rs_len  = RC_W'(SCREEN_WIDTH);
        rs_r0   = '0;
        rs_r1   = RR_W'(SCREEN_HEIGHT - 1);
        rs_full = 1'b1;
      end
      default: ;
    endcase
  end

  // Clip the span to the screen
  always_comb begin
    cend = rs_c0 + rs_len;
    if (cend > RC_W'(SCREEN_WIDTH)) begin
      cend = RC_W'(SCREEN_WIDTH);
    end
    r1c = (rs_r1 >= RR_W'(SCREEN_HEIGHT)) ? RR_W'(SCREEN_HEIGHT - 1) : rs_r1;
    span_empty = (rs_c0 >= RC_W'(SCREEN_WIDTH)) || (cend <= rs_c0) ||
                 (rs_r0 >= RR_W'(SCREEN_HEIGHT)) || (rs_r0 > r1c);
    span.c0     = COL_W'(rs_c0);
    span.c1     = COL_W'(cend - RC_W'(1));
    span.p0     = PAGE_W'(rs_r0 >> 3);
    span.p1     = PAGE_W'(r1c >> 3);
    span.lo     = rs_r0[2:0];
    span.hi     = r1c[2:0];
    span.colour = rs_full ? 1'b0 : colour_q;
    span.full   = rs_full;
  end

  // Byte read address
  assign rd_off  = (RC_W'(x_q) >= RC_W'(SCREEN_WIDTH)) ||
                   (RR_W'(y_q) >= RR_W'(SCREEN_HEIGHT));
  assign rd_addr = byte_addr(COL_W'(x_q), PAGE_W'(y_q >> 3));
  assign raddr   = (state == ST_READ) ? rd_addr : req.addr;

  // Command sequencer
  always_comb begin
    state_next = state;
    cmd_stall  = 1'b1;
    walk_start = 1'b0;
    rsp_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid) begin
          case (op_t'(op))
            OP_PIXEL, OP_HLINE, OP_VLINE, OP_RECT, OP_FILL, OP_CLEAR:
              state_next = ST_SPAN;
            OP_READ: state_next = ST_READ;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_SPAN: begin
        if (span_empty) begin
          state_next = last_k ? ST_DONE : ST_SPAN;
        end else begin
          walk_start = 1'b1;
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (walk_done) begin
          if (init_pass) begin
            state_next = ST_IDLE;
          end else begin
            state_next = last_k ? ST_DONE : ST_SPAN;
          end
        end
      end
      ST_READ: begin
        state_next = rd_off ? ST_DONE : ST_FETCH;
      end
      ST_FETCH: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Start with a clearing pass over the store
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SPAN;
      op_q      <= OP_CLEAR;
      k         <= '0;
      init_pass <= 1'b1;
    end else begin
      state <= state_next;
      if (accept) begin
        op_q <= op_t'(op);
        k    <= '0;
      end else if ((state == ST_SPAN && span_empty && !last_k) ||
                   (state == ST_WAIT && walk_done && !last_k)) begin
        k <= k + 2'd1;
      end
      if (state == ST_WAIT && walk_done) begin
        init_pass <= 1'b0;
      end
    end
  end

  // Hold the command fields and the pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      x_q      <= x;
      y_q      <= y;
      w_q      <= w;
      h_q      <= h;
      colour_q <= colour;
      res_data <= '0;
    end else if (state == ST_FETCH) begin
      res_data <= rdata;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      read_data <= res_data;
    end
  end

  pfde_walker u_walker (
    .clk   (clk),
    .rst   (rst),
    .start (walk_start),
    .span  (span),
    .rdata (rdata),
    .req   (req),
    .done  (walk_done)
  );

  pfde_store u_store (
    .clk   (clk),
    .req   (req),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

[design/pfde_store.sv]
`timescale 1ns / 1ps

module pfde_store
  import pfde_pkg::*;
(
  input  logic              clk,
  input  mem_req_t          req,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [STORE_BYTES];

  // Write one byte, read one byte with registered data
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/pfde_walker.sv]
`timescale 1ns / 1ps

module pfde_walker
  import pfde_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  span_t      span,
  input  logic [7:0] rdata,
  output mem_req_t   req,
  output logic       done
);

  walk_state_t       state, state_next;
  span_t             sp;
  logic [COL_W-1:0]  col;
  logic [PAGE_W-1:0] page;
  logic [2:0]        lo_e, hi_e;
  logic [7:0]        mask;
  logic              last_col, last_page;

  // Row bits of the current page covered by the span
  always_comb begin
    lo_e = (page == sp.p0) ? sp.lo : 3'd0;
    hi_e = (page == sp.p1) ? sp.hi : 3'd7;
    mask = sp.full ? 8'hFF : ((8'hFF << lo_e) & (8'hFF >> (3'd7 - hi_e)));
  end

  assign last_col  = (col == sp.c1);
  assign last_page = (page == sp.p1);

  // Read the byte, then write it back with the mask applied
  always_comb begin
    req.we    = (state == WK_WRITE);
    req.addr  = byte_addr(col, page);
    req.wdata = sp.colour ? (rdata | mask) : (rdata & ~mask);
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    unique case (state)
      WK_IDLE: begin
        if (start) begin
          state_next = WK_READ;
        end
      end
      WK_READ: begin
        state_next = WK_WRITE;
      end
      WK_WRITE: begin
        if (last_col && last_page) begin
          state_next = WK_IDLE;
          done       = 1'b1;
        end else begin
          state_next = WK_READ;
        end
      end
      default: state_next = WK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= WK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance column first, then page
  always_ff @(posedge clk) begin
    if (state == WK_IDLE && start) begin
      sp   <= span;
      col  <= span.c0;
      page <= span.p0;
    end else if (state == WK_WRITE) begin
      if (last_col) begin
        col  <= sp.c0;
        page <= page + PAGE_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule
